// ===== rtl/ecar_pkg.sv =====
// ----------------------------------------------------------------------------
// ecar_pkg : shared types and constants
// Widths, register indexes, op codes and the cell control bundle used by the
// elementary automaton row stepper.
// ----------------------------------------------------------------------------
package ecar_pkg;

    localparam int unsigned MAX_CELLS_DEF = 64;

    localparam int unsigned RULE_W     = 8;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [RULE_W-1:0] RULE_RESET = 8'd30;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_NUMBER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd1;

    // op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic load;    // write the selected cell
        logic shift;   // rotate the ring by one towards cell 0
        logic update;  // replace the ring with the next generation
    } t_cell_ctrl;

endpackage

// ===== rtl/ecar_if.sv =====
// ----------------------------------------------------------------------------
// ecar_if : valid/ready channels
// Input item, result and configuration write channels.
// ----------------------------------------------------------------------------
interface ecar_item_if import ecar_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [POS_W-1:0] load_position;
    logic             load_cell;

    modport source (output valid, output op, output load_position, output load_cell,
                    input ready);
    modport sink   (input valid, input op, input load_position, input load_cell,
                    output ready);
endinterface

interface ecar_res_if import ecar_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_position;
    logic             out_cell;
    logic             last_cell;

    modport source (output valid, output out_position, output out_cell,
                    output last_cell, input ready);
    modport sink   (input valid, input out_position, input out_cell,
                    input last_cell, output ready);
endinterface

interface ecar_cfg_if import ecar_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ecar_cell.sv =====
// ----------------------------------------------------------------------------
// ecar_cell : one cell of the ring
// Holds one state bit; loads, takes its right neighbour on a rotate, or
// applies the rule to its neighbourhood on an update.
// ----------------------------------------------------------------------------
module ecar_cell import ecar_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_sel,
    input  logic              i_in_ring,
    input  logic              i_load_value,
    input  logic              i_left,
    input  logic              i_right,
    input  logic [RULE_W-1:0] i_rule,
    output logic              o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.load && i_sel) begin
            n_bit = i_load_value;
        end else if (i_in_ring && i_ctrl.shift) begin
            n_bit = i_right;
        end else if (i_in_ring && i_ctrl.update) begin
            n_bit = i_rule[{i_left, r_bit, i_right}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== rtl/ecar_seq.sv =====
// ----------------------------------------------------------------------------
// ecar_seq : step sequencer and result register
// Walks the ring out through cell 0 one beat at a time, then fires the
// update state.
// ----------------------------------------------------------------------------
module ecar_seq import ecar_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    input  logic             i_load_ok,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [POS_W-1:0] o_out_pos,
    output logic             o_out_cell,
    output logic             o_out_last,
    input  logic [POS_W-1:0] i_last_idx,
    input  logic             i_cell0,
    output t_cell_ctrl       o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EMIT   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic             r_out_cell, n_out_cell;
    logic             r_out_last, n_out_last;
    logic             w_accept;
    logic             w_adv;
    logic             w_at_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_at_last  = (r_cnt == i_last_idx);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pos   = r_out_pos;
        n_out_cell  = r_out_cell;
        n_out_last  = r_out_last;
        o_ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_op == OP_STEP) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end
                o_ctrl.load = w_accept && (i_in_op == OP_LOAD) && i_load_ok;
            end
            S_EMIT: begin
                if (w_adv) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = r_cnt;
                    n_out_cell   = i_cell0;
                    n_out_last   = w_at_last;
                    o_ctrl.shift = 1'b1;
                    if (w_at_last) begin
                        n_state = S_UPDATE;
                    end else begin
                        n_cnt = r_cnt + POS_W'(1);
                    end
                end
            end
            S_UPDATE: begin
                o_ctrl.update = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_out_pos  <= n_out_pos;
        r_out_cell <= n_out_cell;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pos   = r_out_pos;
    assign o_out_cell  = r_out_cell;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/elementary_ca_row_step.sv =====
// A load item is taken while idle and a new item can follow at once.
// A step item (n = clamped row length, 1..MAX_CELLS) runs n beats that rotate
// the ring out through cell 0, the update and a return to idle; its first
// result passes the state, then the result register. Output stalls hold beats.
// Reset (synchronous, active low): all cells zero, rule 30, row length 64.
// ----------------------------------------------------------------------------
// elementary_ca_row_step : elementary cellular automaton row stepper
// A ring of one-bit cells evolving under an 8-bit rule; load and step items.
// ----------------------------------------------------------------------------
module elementary_ca_row_step import ecar_pkg::*; #(
    parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecar_item_if.sink  i_item,
    ecar_res_if.source o_res,
    ecar_cfg_if.sink   i_cfg
);

    // config registers
    logic [RULE_W-1:0] r_rule;
    logic [LEN_W-1:0]  r_len;

    // ring
    logic [MAX_CELLS-1:0] w_row;
    logic [MAX_CELLS-1:0] w_in_ring;
    logic [MAX_CELLS-1:0] w_last;
    logic [MAX_CELLS-1:0] w_sel;
    logic [LEN_W-1:0]     w_len;      // clamped active length
    logic [LEN_W-1:0]     w_len_m1;
    logic                 w_wrap;     // left neighbour of cell 0
    logic                 w_load_ok;
    t_cell_ctrl           w_ctrl;

    // Config port always ready; the user must write only while idle, the block itself does not enforce it.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_RESET;
            r_len  <= LEN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RULE_NUMBER: r_rule <= i_cfg.data;
                CFG_ROW_LENGTH:  r_len  <= i_cfg.data[LEN_W-1:0];
                default: ;       // unmapped index, ignored
            endcase
        end
    end

    // Zero length acts as one cell; anything past storage is capped.
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_CELLS)) begin
            w_len = LEN_W'(MAX_CELLS);
        end else begin
            w_len = r_len;
        end
    end
    assign w_len_m1 = w_len - LEN_W'(1);

    // Loads past the physical storage are dropped.
    assign w_load_ok = ({1'b0, i_item.load_position} < LEN_W'(MAX_CELLS));

    // Cell n-1 is one-hot in w_last, so the wrap is a masked OR.
    assign w_wrap = |(w_row & w_last);

    for (genvar gi = 0; gi < MAX_CELLS; gi++) begin : g_cell
        logic w_right;
        logic w_left;

        assign w_in_ring[gi] = (LEN_W'(gi) < w_len);
        assign w_last[gi]    = (LEN_W'(gi) == w_len_m1);
        assign w_sel[gi]     = (i_item.load_position == POS_W'(gi));

        // right neighbour doubles as rotate source; the last live cell wraps to 0
        if (gi == MAX_CELLS - 1) begin : g_top
            assign w_right = w_row[0];
        end else begin : g_mid
            assign w_right = w_last[gi] ? w_row[0] : w_row[gi+1];
        end

        if (gi == 0) begin : g_first
            assign w_left = w_wrap;
        end else begin : g_rest
            assign w_left = w_row[gi-1];
        end

        ecar_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_sel        (w_sel[gi]),
            .i_in_ring    (w_in_ring[gi]),
            .i_load_value (i_item.load_cell),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_rule       (r_rule),
            .o_bit        (w_row[gi])
        );
    end

    // Sequencer: emits cell 0 each beat while the ring rotates, so after n
    // beats the row is back in place for the update cycle.
    ecar_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.op),
        .i_load_ok   (w_load_ok),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_pos   (o_res.out_position),
        .o_out_cell  (o_res.out_cell),
        .o_out_last  (o_res.last_cell),
        .i_last_idx  (w_len_m1[POS_W-1:0]),
        .i_cell0     (w_row[0]),
        .o_ctrl      (w_ctrl)
    );

endmodule

// ===== rtl/ecar_chk.sv =====
// ----------------------------------------------------------------------------
// ecar_chk : port-level checks
// Watches the item and result channels of the row stepper.
// ----------------------------------------------------------------------------
module ecar_chk import ecar_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_op,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [POS_W-1:0] i_out_pos,
    input logic             i_out_cell,
    input logic             i_out_last
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_pos) && $stable(i_out_cell) && $stable(i_out_last))
        else $error("result beat changed under stall");

    // a step blocks further items
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == OP_STEP |=> !i_in_ready)
        else $error("item taken right after a step");

    // mid-row beat means the row is still going out
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("item ready while a row is being emitted");

    // taking a mid-row beat brings the next position straight away
    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && i_out_pos == POS_W'($past(i_out_pos) + POS_W'(1)))
        else $error("result positions out of order");

endmodule

bind elementary_ca_row_step ecar_chk u_ecar_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.op),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pos   (o_res.out_position),
    .i_out_cell  (o_res.out_cell),
    .i_out_last  (o_res.last_cell)
);
